FILE: rtl/core/msph_pkg.sv
`default_nettype none
package msph_pkg;

  // Field and datapath widths
  localparam int unsigned COMP_W    = 16;  // one packed Q7.8 component
  localparam int unsigned DIFF_W    = 17;  // difference of two components
  localparam int unsigned PROD_W    = 34;  // product of two differences
  localparam int unsigned SQ_W      = 34;  // a, c, |b| and the square root
  localparam int unsigned VS_W      = 36;  // signed dot product sum, c before clamp
  localparam int unsigned D_W       = 68;  // b*b, a*c and discriminant
  localparam int unsigned REM_W     = SQ_W + 3;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned TIME_FRAC = 8;
  localparam int unsigned NUM_W     = SQ_W + TIME_FRAC;
  localparam int unsigned DREM_W    = SQ_W + TIME_W;
  localparam int unsigned THR_W     = 16;

  localparam int unsigned SQRT_STAGES = SQ_W;
  localparam int unsigned DIV_STAGES  = TIME_W;
  // front end (6) + root + numerator + divider setup + divider + output
  localparam int unsigned LATENCY = 6 + SQRT_STAGES + 1 + 1 + DIV_STAGES + 1;

  localparam logic [2:0] OUTCOME_OVERLAP  = 3'd0;
  localparam logic [2:0] OUTCOME_STILL    = 3'd1;
  localparam logic [2:0] OUTCOME_RECEDING = 3'd2;
  localparam logic [2:0] OUTCOME_NO_ROOT  = 3'd3;
  localparam logic [2:0] OUTCOME_HIT      = 3'd4;

  // Per-item sideband that rides along the root and divider pipelines
  typedef struct packed {
    logic [2:0]      outcome;
    logic [SQ_W-1:0] mb;
    logic [SQ_W-1:0] a;
  } side_t;

endpackage
`default_nettype wire

FILE: rtl/core/moving_sphere_pair_hit_time_top.sv
`default_nettype none
// Moving sphere pair hit time. Pulse start with a sphere pair (centres, radii and
// per-step motions, packed Q7.8 / Q8.8); exactly one item comes back with hit, outcome
// and time_of_impact, marked by a one-cycle done strobe. The block is fully
// pipelined: a new pair is taken every cycle, and busy is high only while rst is
// high. The latency is set by the square root (one result bit per stage, 34 stages)
// and the Q8.8 divider (one quotient bit per stage, 16 stages plus a saturation
// check), behind six front-end stages that form the differences, products, dot
// products, classification, b*b and a*c, and the discriminant. done cannot be
// held off: capture the item in the cycle it is shown. Thresholds sit on the APB
// port at 0x0 (overlap) and 0x4 (motion); write them only while no item is in flight.
module moving_sphere_pair_hit_time_top #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item in
  input  wire logic        start,
  output logic             busy,
  input  wire logic [47:0] centre_a,
  input  wire logic [15:0] radius_a,
  input  wire logic [47:0] centre_b,
  input  wire logic [15:0] radius_b,
  input  wire logic [47:0] motion_a,
  input  wire logic [47:0] motion_b,
  // item out
  output logic             done,
  output logic             hit,
  output logic [2:0]       outcome,
  output logic [15:0]      time_of_impact,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned THRESH_RESET =
    ((1 << (2 * COORD_FRAC_BITS)) + 500) / 1000;
  localparam int unsigned DW = msph_pkg::DIFF_W;
  localparam int unsigned PW = msph_pkg::PROD_W;
  localparam int unsigned QW = msph_pkg::SQ_W;
  localparam int unsigned VW = msph_pkg::VS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [msph_pkg::THR_W-1:0] overlap_threshold;
  logic [msph_pkg::THR_W-1:0] motion_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_threshold <= msph_pkg::THR_W'(THRESH_RESET);
      motion_threshold  <= msph_pkg::THR_W'(THRESH_RESET);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        motion_threshold <= pwdata[msph_pkg::THR_W-1:0];
      end else begin
        overlap_threshold <= pwdata[msph_pkg::THR_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'h0000, motion_threshold} : {16'h0000, overlap_threshold};

  // Nothing in the pipe can stall; refuse items only while in reset.
  assign busy = rst;

  // ---------------------------------------------------------------------------
  // Stage 1: relative offset s, relative motion v, summed radius r
  // ---------------------------------------------------------------------------
  logic                 s1_vld;
  logic signed [DW-1:0] s1_s [0:2];
  logic signed [DW-1:0] s1_v [0:2];
  logic [DW-1:0]        s1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
    for (int k = 0; k < 3; k++) begin
      s1_s[k] <= $signed({centre_b[16*k+15], centre_b[16*k +: 16]}) -
                 $signed({centre_a[16*k+15], centre_a[16*k +: 16]});
      s1_v[k] <= $signed({motion_b[16*k+15], motion_b[16*k +: 16]}) -
                 $signed({motion_a[16*k+15], motion_a[16*k +: 16]});
    end
    s1_r <= {1'b0, radius_a} + {1'b0, radius_b};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per-component products and r squared
  // ---------------------------------------------------------------------------
  logic                 s2_vld;
  logic [PW-2:0]        s2_ss [0:2];
  logic [PW-2:0]        s2_vv [0:2];
  logic signed [PW-1:0] s2_vs [0:2];
  logic [PW-1:0]        s2_r2;
  logic signed [PW-1:0] ss_full [0:2];
  logic signed [PW-1:0] vv_full [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ss_full[k] = s1_s[k] * s1_s[k];
      vv_full[k] = s1_v[k] * s1_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    for (int k = 0; k < 3; k++) begin
      s2_ss[k] <= ss_full[k][PW-2:0];
      s2_vv[k] <= vv_full[k][PW-2:0];
      s2_vs[k] <= s1_v[k] * s1_s[k];
    end
    s2_r2 <= s1_r * s1_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot products s.s, v.v, v.s
  // ---------------------------------------------------------------------------
  logic                 s3_vld;
  logic [QW-1:0]        s3_ss;
  logic [QW-1:0]        s3_vv;
  logic signed [VW-1:0] s3_vs;
  logic [PW-1:0]        s3_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_ss <= {1'b0, s2_ss[0]} + {1'b0, s2_ss[1]} + {1'b0, s2_ss[2]};
    s3_vv <= {1'b0, s2_vv[0]} + {1'b0, s2_vv[1]} + {1'b0, s2_vv[2]};
    s3_vs <= VW'(s2_vs[0]) + VW'(s2_vs[1]) + VW'(s2_vs[2]);
    s3_r2 <= s2_r2;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: c = s.s - r^2 and the early outcomes (overlap, still, receding)
  // ---------------------------------------------------------------------------
  logic signed [VW-1:0] c_val;
  logic signed [VW-1:0] vs_neg;
  logic [2:0]           cls;

  assign c_val  = $signed({2'b00, s3_ss}) - $signed({2'b00, s3_r2});
  assign vs_neg = -s3_vs;

  always_comb begin
    if (c_val < $signed({{(VW - msph_pkg::THR_W){1'b0}}, overlap_threshold})) begin
      cls = msph_pkg::OUTCOME_OVERLAP;
    end else if ((s3_vv < {{(QW - msph_pkg::THR_W){1'b0}}, motion_threshold}) ||
                 (s3_vv == '0)) begin
      cls = msph_pkg::OUTCOME_STILL;
    end else if (s3_vs > 0) begin
      cls = msph_pkg::OUTCOME_RECEDING;
    end else begin
      cls = msph_pkg::OUTCOME_HIT;
    end
  end

  logic            s4_vld;
  msph_pkg::side_t s4_side;
  logic [QW-1:0]   s4_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_side.outcome <= cls;
    s4_side.mb      <= vs_neg[QW-1:0];
    s4_side.a       <= s3_vv;
    s4_c            <= c_val[QW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 5: b*b and a*c
  // ---------------------------------------------------------------------------
  logic                      s5_vld;
  msph_pkg::side_t           s5_side;
  logic [msph_pkg::D_W-1:0]  s5_bb;
  logic [msph_pkg::D_W-1:0]  s5_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_side <= s4_side;
    s5_bb   <= s4_side.mb * s4_side.mb;
    s5_ac   <= s4_side.a * s4_c;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: discriminant; drop to no-root when it goes negative
  // ---------------------------------------------------------------------------
  logic                      s6_vld;
  msph_pkg::side_t           s6_side;
  logic [msph_pkg::D_W-1:0]  s6_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_side <= s5_side;
    if ((s5_side.outcome == msph_pkg::OUTCOME_HIT) && (s5_ac > s5_bb)) begin
      s6_side.outcome <= msph_pkg::OUTCOME_NO_ROOT;
    end
    s6_d <= s5_bb - s5_ac;
  end

  // ---------------------------------------------------------------------------
  // Square root of the discriminant
  // ---------------------------------------------------------------------------
  logic            rt_vld;
  logic [QW-1:0]   rt_root;
  msph_pkg::side_t rt_side;

  msph_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_vld),
    .in_d      (s6_d),
    .in_side   (s6_side),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // Numerator (-b - root) in Q8 units.
  logic                        nm_vld;
  logic [msph_pkg::NUM_W-1:0]  nm_num;
  msph_pkg::side_t             nm_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_vld <= 1'b0;
    end else begin
      nm_vld <= rt_vld;
    end
    nm_num  <= {rt_side.mb - rt_root, {msph_pkg::TIME_FRAC{1'b0}}};
    nm_side <= rt_side;
  end

  // ---------------------------------------------------------------------------
  // Divide by a, saturate, and register the item out
  // ---------------------------------------------------------------------------
  logic                         dv_vld;
  logic [msph_pkg::TIME_W-1:0]  dv_quot;
  msph_pkg::side_t              dv_side;

  msph_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nm_vld),
    .in_num    (nm_num),
    .in_side   (nm_side),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld;
    end
    outcome        <= dv_side.outcome;
    hit            <= (dv_side.outcome == msph_pkg::OUTCOME_OVERLAP) ||
                      (dv_side.outcome == msph_pkg::OUTCOME_HIT);
    time_of_impact <= (dv_side.outcome == msph_pkg::OUTCOME_HIT) ? dv_quot : '0;
  end

endmodule
`default_nettype wire

FILE: rtl/core/msph_isqrt.sv
`default_nettype none
module msph_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [msph_pkg::D_W-1:0]     in_d,
  input  wire msph_pkg::side_t              in_side,
  output logic                              out_valid,
  output logic [msph_pkg::SQ_W-1:0]         out_root,
  output msph_pkg::side_t                   out_side
);

  localparam int unsigned N = msph_pkg::SQRT_STAGES;

  logic                          vld_q  [0:N-1];
  logic [msph_pkg::D_W-1:0]      d_q    [0:N-1];
  logic [msph_pkg::REM_W-1:0]    rem_q  [0:N-1];
  logic [msph_pkg::SQ_W-1:0]     root_q [0:N-1];
  msph_pkg::side_t               side_q [0:N-1];

  // One result bit per stage: bring down two bits, try (root << 2) | 1.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                          v_in;
    logic [msph_pkg::D_W-1:0]      d_in;
    logic [msph_pkg::REM_W-1:0]    rem_in;
    logic [msph_pkg::SQ_W-1:0]     root_in;
    msph_pkg::side_t               side_in;
    logic [msph_pkg::REM_W-1:0]    rem_sh;
    logic [msph_pkg::REM_W-1:0]    trial;
    logic                          ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign d_in    = in_d;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign d_in    = d_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_sh = {rem_in[msph_pkg::REM_W-3:0], d_in[msph_pkg::D_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
      d_q[k]    <= {d_in[msph_pkg::D_W-3:0], 2'b00};
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {root_in[msph_pkg::SQ_W-2:0], ge};
      side_q[k] <= side_in;
    end
  end

  assign out_valid = vld_q[N-1];
  assign out_root  = root_q[N-1];
  assign out_side  = side_q[N-1];

endmodule
`default_nettype wire

FILE: rtl/core/msph_div.sv
`default_nettype none
module msph_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [msph_pkg::NUM_W-1:0]   in_num,
  input  wire msph_pkg::side_t              in_side,
  output logic                              out_valid,
  output logic [msph_pkg::TIME_W-1:0]       out_quot,
  output msph_pkg::side_t                   out_side
);

  localparam int unsigned N  = msph_pkg::DIV_STAGES;
  localparam int unsigned RW = msph_pkg::DREM_W;

  // Setup stage: flag quotients that do not fit in the time field.
  logic             pre_vld;
  logic [RW-1:0]    pre_rem;
  logic             pre_sat;
  msph_pkg::side_t  pre_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else begin
      pre_vld <= in_valid;
    end
    pre_rem  <= {{(RW - msph_pkg::NUM_W){1'b0}}, in_num};
    pre_sat  <= ({{(RW - msph_pkg::NUM_W){1'b0}}, in_num} >=
                 {in_side.a, {msph_pkg::TIME_W{1'b0}}});
    pre_side <= in_side;
  end

  logic                          vld_q  [0:N-1];
  logic [RW-1:0]                 rem_q  [0:N-1];
  logic [msph_pkg::TIME_W-1:0]   quot_q [0:N-1];
  logic                          sat_q  [0:N-1];
  msph_pkg::side_t               side_q [0:N-1];

  // Restoring division, one quotient bit per stage, MSB first.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                          v_in;
    logic [RW-1:0]                 rem_in;
    logic [msph_pkg::TIME_W-1:0]   quot_in;
    logic                          sat_in;
    msph_pkg::side_t               side_in;
    logic [RW-1:0]                 dvs;
    logic                          ge;

    if (k == 0) begin : g_first
      assign v_in    = pre_vld;
      assign rem_in  = pre_rem;
      assign quot_in = '0;
      assign sat_in  = pre_sat;
      assign side_in = pre_side;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quot_in = quot_q[k-1];
      assign sat_in  = sat_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dvs = {{msph_pkg::TIME_W{1'b0}}, side_in.a} << (N - 1 - k);
    assign ge  = (rem_in >= dvs);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
      rem_q[k]  <= ge ? (rem_in - dvs) : rem_in;
      quot_q[k] <= {quot_in[msph_pkg::TIME_W-2:0], ge};
      sat_q[k]  <= sat_in;
      side_q[k] <= side_in;
    end
  end

  assign out_valid = vld_q[N-1];
  assign out_quot  = sat_q[N-1] ? {msph_pkg::TIME_W{1'b1}} : quot_q[N-1];
  assign out_side  = side_q[N-1];

endmodule
`default_nettype wire

FILE: rtl/core/msph_checker.sv
`default_nettype none
module msph_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        hit,
  input wire logic [2:0]  outcome,
  input wire logic [15:0] time_of_impact
);

  localparam int unsigned LAG = msph_pkg::LATENCY;

  // Count cycles since reset so the latency checks look only at items taken after it.
  logic [6:0] warm_cnt;
  logic       warm;

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_cnt <= '0;
    end else if (!warm) begin
      warm_cnt <= warm_cnt + 7'd1;
    end
  end

  assign warm = (warm_cnt >= 7'(LAG));

  a_hit_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit == ((outcome == msph_pkg::OUTCOME_OVERLAP) ||
                      (outcome == msph_pkg::OUTCOME_HIT))))
    else $error("hit does not agree with outcome");

  a_time_zero_unless_hit: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome != msph_pkg::OUTCOME_HIT)) |-> (time_of_impact == 16'd0))
    else $error("time_of_impact set without a hit");

  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    (warm && $past(start && !busy, LAG)) |-> done)
    else $error("accepted item not delivered at fixed latency");

  a_no_invented_item: assert property (@(posedge clk) disable iff (rst)
    (warm && done) |-> $past(start && !busy, LAG))
    else $error("item delivered without a matching start");

endmodule

bind moving_sphere_pair_hit_time_top msph_checker u_msph_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .hit            (hit),
  .outcome        (outcome),
  .time_of_impact (time_of_impact)
);
`default_nettype wire

FILE: verif/moving_sphere_pair_hit_time_top_tb.sv
`default_nettype none
module moving_sphere_pair_hit_time_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REG_OVERLAP = 0;
  localparam int unsigned REG_MOTION = 1;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [47:0] centre_a, centre_b, motion_a, motion_b;
  logic [15:0] radius_a, radius_b;
  logic done;
  logic hit;
  logic [2:0] outcome;
  logic [15:0] time_of_impact;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  typedef struct packed {
    logic        hit;
    logic [2:0]  outcome;
    logic [15:0] toi;
  } hit_result_t;

  hit_result_t pending_hits[$];
  logic [15:0] overlap_thr;
  logic [15:0] motion_thr;
  bit failed;
  bit idle_enable;
  int unsigned quiet_cycles;

  moving_sphere_pair_hit_time_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .centre_a(centre_a), .radius_a(radius_a), .centre_b(centre_b),
    .radius_b(radius_b), .motion_a(motion_a), .motion_b(motion_b),
    .done(done), .hit(hit), .outcome(outcome), .time_of_impact(time_of_impact),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Sign-extend one packed Q7.8 component.
  function automatic logic signed [63:0] comp(input logic [47:0] p, input int k);
    logic [15:0] x;
    x = p[16*k +: 16];
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [34:0] root_floor(input logic [127:0] d);
    logic [34:0] r;
    logic [34:0] cand;
    r = '0;
    for (int i = 34; i >= 0; i--) begin
      cand = r | (35'd1 << i);
      if ({93'd0, cand} * {93'd0, cand} <= d) r = cand;
    end
    return r;
  endfunction

  // Classify one sphere pair and compute its touch time.
  function automatic hit_result_t pair_hit_time(input logic [47:0] ca, input logic [15:0] ra,
                                                input logic [47:0] cb, input logic [15:0] rb,
                                                input logic [47:0] ma, input logic [47:0] mb_in);
    logic signed [63:0] ss, vv, vs, s, v, r, c;
    logic [127:0] bb, ac;
    logic [63:0] mb, q, t;
    hit_result_t res;
    ss = 0;
    vv = 0;
    vs = 0;
    for (int k = 0; k < 3; k++) begin
      s = comp(cb, k) - comp(ca, k);
      v = comp(mb_in, k) - comp(ma, k);
      ss += s * s;
      vv += v * v;
      vs += v * s;
    end
    r = $signed({48'd0, ra}) + $signed({48'd0, rb});
    c = ss - r * r;
    res = '0;
    if (c < $signed({48'd0, overlap_thr})) begin
      res.hit = 1'b1;
      res.outcome = msph_pkg::OUTCOME_OVERLAP;
    end else if (vv < $signed({48'd0, motion_thr}) || vv == 0) begin
      res.outcome = msph_pkg::OUTCOME_STILL;
    end else if (vs > 0) begin
      res.outcome = msph_pkg::OUTCOME_RECEDING;
    end else begin
      mb = -vs;
      bb = {64'd0, mb} * {64'd0, mb};
      ac = {64'd0, vv} * {64'd0, c};
      if (ac > bb) begin
        res.outcome = msph_pkg::OUTCOME_NO_ROOT;
      end else begin
        q = 64'(root_floor(bb - ac));
        t = ((mb - q) << 8) / vv;
        res.hit = 1'b1;
        res.outcome = msph_pkg::OUTCOME_HIT;
        res.toi = (t > 64'hFFFF) ? 16'hFFFF : t[15:0];
      end
    end
    return res;
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    hit_result_t want;
    if (!rst && done) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0d outcome=%0d toi=%h",
                 $time, hit, outcome, time_of_impact);
        failed = 1'b1;
      end else begin
        want = pending_hits.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
          failed = 1'b1;
        end
        if (outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome);
          failed = 1'b1;
        end
        if (time_of_impact !== want.toi) begin
          $display("%0t: time_of_impact expected %h actual %h",
                   $time, want.toi, time_of_impact);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles with no item moving either way.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drop start for a random burst of idle cycles.
  task automatic random_idle();
    int unsigned n;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drive one item, hold start until it is taken, then record its expectation.
  task automatic send_pair(input logic [47:0] ca, input logic [15:0] ra,
                           input logic [47:0] cb, input logic [15:0] rb,
                           input logic [47:0] ma, input logic [47:0] mb);
    random_idle();
    start <= 1'b1;
    centre_a <= ca;
    radius_a <= ra;
    centre_b <= cb;
    radius_b <= rb;
    motion_a <= ma;
    motion_b <= mb;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hits.push_back(pair_hit_time(ca, ra, cb, rb, ma, mb));
  endtask

  // Wait out every expected result plus the pipeline depth before touching registers.
  task automatic drain();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (msph_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_OVERLAP) overlap_thr = value[15:0];
    else if (idx == REG_MOTION) motion_thr = value[15:0];
    @(posedge clk);
  endtask

  function automatic logic [47:0] vec(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [47:0] small_vec(input int lim);
    return vec($urandom_range(0, 2 * lim) - lim, $urandom_range(0, 2 * lim) - lim,
               $urandom_range(0, 2 * lim) - lim);
  endfunction

  task automatic test_directed();
    // overlap, still, receding, no root, plain hit
    send_pair(vec(0, 0, 0), 16'h0100, vec(256, 0, 0), 16'h0100, '0, '0);
    send_pair(vec(0, 0, 0), 16'h0100, vec(2560, 0, 0), 16'h0100, '0, '0);
    send_pair(vec(0, 0, 0), 16'h0100, vec(2560, 0, 0), 16'h0100, '0, vec(256, 0, 0));
    send_pair(vec(0, 0, 0), 16'h0100, vec(2560, 2560, 0), 16'h0100, '0, vec(-256, 0, 0));
    send_pair(vec(0, 0, 0), 16'h0100, vec(2560, 0, 0), 16'h0100, '0, vec(-512, 0, 0));
    // slow approaches: one still, one late hit that saturates the time
    send_pair(vec(-32768, 0, 0), 16'h0000, vec(32767, 0, 0), 16'h0000, '0, vec(-1, 0, 0));
    send_pair(vec(-32768, 0, 0), 16'h0000, vec(32767, 0, 0), 16'h0000, '0, vec(-9, 0, 0));
    // field extremes
    send_pair('0, 16'h0000, '0, 16'h0000, '0, '0);
    send_pair('1, 16'hFFFF, '1, 16'hFFFF, '1, '1);
    send_pair(vec(-32768, -32768, -32768), 16'h0000, vec(32767, 32767, 32767), 16'h0000,
              vec(32767, 32767, 32767), vec(-32768, -32768, -32768));
    send_pair(vec(32767, -32768, 32767), 16'h8000, vec(-32768, 32767, -32768), 16'h0001,
              vec(-32768, 32767, -32768), vec(32767, -32768, 32767));
    send_pair(vec(0, 0, 0), 16'h0000, vec(0, 0, 3000), 16'h0000, vec(0, 0, 8), vec(0, 0, 0));
  endtask

  task automatic test_thresholds();
    // Zero thresholds: no overlap by threshold, still only when motion is exactly zero.
    write_reg(REG_OVERLAP, 32'h0);
    write_reg(REG_MOTION, 32'h0);
    send_pair(vec(0, 0, 0), 16'h0100, vec(512, 0, 0), 16'h0100, '0, '0);
    send_pair(vec(0, 0, 0), 16'h0000, vec(0, 0, 0), 16'h0000, '0, '0);
    send_pair(vec(0, 0, 0), 16'h0000, vec(100, 0, 0), 16'h0000, '0, vec(-1, 0, 0));
    drain();
    // Maximum thresholds, upper bits of the write dropped.
    write_reg(REG_OVERLAP, 32'hABCD_FFFF);
    write_reg(REG_MOTION, 32'h5555_FFFF);
    send_pair(vec(0, 0, 0), 16'h0000, vec(200, 0, 0), 16'h0000, '0, vec(-200, 0, 0));
    send_pair(vec(0, 0, 0), 16'h0000, vec(2000, 0, 0), 16'h0000, '0, vec(-200, 0, 0));
    send_pair(vec(0, 0, 0), 16'h0000, vec(2000, 0, 0), 16'h0000, '0, vec(-300, 0, 0));
    drain();
  endtask

  // Mostly near pairs with random motion so every outcome shows up often.
  task automatic test_random(input int unsigned count);
    logic [47:0] ca, cb, ma, mb;
    logic [15:0] ra, rb;
    int unsigned mode;
    for (int unsigned i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        ca = small_vec(3000);
        cb = small_vec(3000);
        ma = small_vec(600);
        mb = small_vec(600);
        ra = 16'($urandom_range(0, 1200));
        rb = 16'($urandom_range(0, 1200));
      end else if (mode < 9) begin
        ca = 48'({$urandom, $urandom});
        cb = 48'({$urandom, $urandom});
        ma = 48'({$urandom, $urandom});
        mb = 48'({$urandom, $urandom});
        ra = 16'($urandom);
        rb = 16'($urandom);
      end else begin
        ca = small_vec(20000);
        cb = small_vec(20000);
        ma = small_vec(8);
        mb = small_vec(8);
        ra = 16'($urandom_range(0, 255));
        rb = 16'($urandom_range(0, 255));
      end
      send_pair(ca, ra, cb, rb, ma, mb);
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    centre_a <= '0;
    radius_a <= '0;
    centre_b <= '0;
    radius_b <= '0;
    motion_a <= '0;
    motion_b <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    failed = 1'b0;
    idle_enable = 1'b1;
    overlap_thr = 16'd66;
    motion_thr = 16'd66;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    drain();
    test_thresholds();
    write_reg(REG_OVERLAP, 32'd66);
    write_reg(REG_MOTION, 32'd500);
    test_random(200);
    // Hold the sender until the pipeline is empty once mid-run.
    drain();
    write_reg(REG_OVERLAP, 32'd3000);
    write_reg(REG_MOTION, 32'd66);
    test_random(150);
    drain();
    write_reg(REG_OVERLAP, 32'd66);
    // Last part: back-to-back items, no gaps.
    idle_enable = 1'b0;
    test_random(150);
    drain();

    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

FILE: moving_sphere_pair_hit_time_top.f
rtl/core/msph_pkg.sv
rtl/core/msph_isqrt.sv
rtl/core/msph_div.sv
rtl/core/moving_sphere_pair_hit_time_top.sv
rtl/core/msph_checker.sv
verif/moving_sphere_pair_hit_time_top_tb.sv
